>>> sv/vsr_pkg.sv
// shared types and constants for the ventilation setpoint regulator
// no dependencies

`default_nettype none

package vsr_pkg;

    // saturation limits
    localparam int unsigned PRESSURE_MAX = 125;
    localparam int unsigned SPEED_MAX    = 1000;

    // knob step sizes
    localparam int unsigned PA_STEP      = 1;
    localparam int unsigned SPEED_STEP   = 10;

    // field widths
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned SPEED_W = 10;
    localparam int unsigned PA_W    = 7;
    localparam int unsigned IDX_W   = 2;

    // event codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd5;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ADJUST_INTERVAL = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_TARGET      = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEAD_BAND       = 2'd2;

    // register reset values
    localparam logic [TIME_W-1:0] ADJUST_INTERVAL_RST = 32'd1000000;
    localparam logic [PA_W-1:0]   MIN_TARGET_RST      = 7'd0;
    localparam logic [PA_W-1:0]   DEAD_BAND_RST       = 7'd1;

    // raw / 240 = (|raw| >> 4) / 15, the /15 as multiply by 2185 >> 15
    localparam int unsigned RECIP_15     = 2185;
    localparam int unsigned RECIP_SHIFT  = 15;

    // fan command from the control law
    typedef struct packed {
        logic               write;
        logic [SPEED_W-1:0] speed;
    } fan_cmd_t;

endpackage

`default_nettype wire

>>> sv/vsr_fan_law.sv
// proportional fan law with dead band for an auto-mode tick
// depends on vsr_pkg

`default_nettype none

module vsr_fan_law (
    input  wire logic [vsr_pkg::PA_W-1:0]    target_pa,
    input  wire logic [vsr_pkg::PA_W-1:0]    min_target,
    input  wire logic [vsr_pkg::PA_W-1:0]    dead_band,
    input  wire logic [vsr_pkg::RAW_W-1:0]   raw_pressure,
    input  wire logic [vsr_pkg::SPEED_W-1:0] fan_speed_now,
    output vsr_pkg::fan_cmd_t                cmd
);

    logic [15:0]        raw_mag;
    logic [11:0]        raw_div16;
    logic [23:0]        prod;
    logic [7:0]         pa_mag;
    logic signed [10:0] pa;
    logic signed [10:0] err;
    logic [9:0]         err_mag;
    logic signed [13:0] five_err;
    logic signed [13:0] sum;
    logic [9:0]         sat_speed;
    logic               over_band;

    // magnitude of the reading, truncation toward zero follows from dividing it
    assign raw_mag   = raw_pressure[15] ? (~raw_pressure + 16'd1) : raw_pressure;
    assign raw_div16 = raw_mag[15:4];
    assign prod      = {12'd0, raw_div16} * 24'(vsr_pkg::RECIP_15);
    assign pa_mag    = 8'(prod >> vsr_pkg::RECIP_SHIFT);
    assign pa        = raw_pressure[15] ? -$signed({3'b000, pa_mag}) : $signed({3'b000, pa_mag});

    assign err       = $signed({4'b0000, target_pa}) - pa;
    assign err_mag   = err[10] ? 10'(-err) : err[9:0];
    assign over_band = err_mag > {3'b000, dead_band};

    assign five_err  = $signed({{3{err[10]}}, err}) + $signed({err[10], err, 2'b00});
    assign sum       = $signed({4'b0000, fan_speed_now}) + five_err;

    always_comb
    begin
        if (sum[13])
            sat_speed = '0;
        else if (sum > 14'(vsr_pkg::SPEED_MAX))
            sat_speed = 10'(vsr_pkg::SPEED_MAX);
        else
            sat_speed = sum[9:0];
    end

    always_comb
    begin
        if (target_pa > min_target)
        begin
            cmd.write = over_band;
            cmd.speed = over_band ? sat_speed : '0;
        end
        else
        begin
            // target at or below minimum: stop the fan
            cmd.write = (fan_speed_now != '0);
            cmd.speed = '0;
        end
    end

endmodule

`default_nettype wire

>>> sv/ventilation_setpoint_regulator.sv
// top level of the ventilation setpoint regulator: input register, event
// processing with the setpoint state, result register; depends on vsr_pkg, vsr_fan_law

// Each input beat is one event (tick, knob up/down, set, back, mode toggle) and
// yields exactly one result beat carrying the fan command and the state after the
// event. An event is captured in an input register, processed by short logic that
// also updates the setpoint state, and moves into a result register when that
// register is free or draining; one event per cycle is sustained while out_ready
// stays high. The state update at the result register is the only loop, so a new
// event can enter every cycle. in_ready drops only while both the input and the
// result register are full and the result is not taken. The configuration port
// is always ready; registers should be written only while no events are in
// flight. The raw sensor reading is turned into pascal by a constant reciprocal
// multiply (divide by 240, truncated toward zero).

`default_nettype none

module ventilation_setpoint_regulator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // event channel
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [vsr_pkg::CMD_W-1:0]     command,
    input  wire logic [vsr_pkg::TIME_W-1:0]    now_us,
    input  wire logic [vsr_pkg::RAW_W-1:0]     raw_pressure,
    input  wire logic [vsr_pkg::SPEED_W-1:0]   fan_speed_now,
    // result channel
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic                          fan_write,
    output      logic [vsr_pkg::SPEED_W-1:0]   fan_command,
    output      logic                          auto_mode,
    output      logic [vsr_pkg::PA_W-1:0]      pressure_target,
    output      logic [vsr_pkg::SPEED_W-1:0]   fan_target,
    output      logic [vsr_pkg::PA_W-1:0]      pending_pressure,
    output      logic [vsr_pkg::SPEED_W-1:0]   pending_fan,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [vsr_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [vsr_pkg::TIME_W-1:0]    cfg_data
);

    // configuration registers
    logic [vsr_pkg::TIME_W-1:0]  adjust_interval_reg;
    logic [vsr_pkg::PA_W-1:0]    min_target_reg;
    logic [vsr_pkg::PA_W-1:0]    dead_band_reg;

    // input register
    logic                        in_valid_reg;
    logic [vsr_pkg::CMD_W-1:0]   cmd_reg;
    logic [vsr_pkg::TIME_W-1:0]  now_reg;
    logic [vsr_pkg::RAW_W-1:0]   raw_reg;
    logic [vsr_pkg::SPEED_W-1:0] fan_now_reg;

    // setpoint state
    logic                        auto_reg,        auto_next;
    logic [vsr_pkg::PA_W-1:0]    target_pa_reg,   target_pa_next;
    logic [vsr_pkg::SPEED_W-1:0] target_spd_reg,  target_spd_next;
    logic [vsr_pkg::PA_W-1:0]    edit_pa_reg,     edit_pa_next;
    logic [vsr_pkg::SPEED_W-1:0] edit_spd_reg,    edit_spd_next;
    logic [vsr_pkg::TIME_W-1:0]  last_adjust_reg, last_adjust_next;

    // result register
    logic                        out_valid_reg;
    logic                        fan_write_reg,   fan_write_next;
    logic [vsr_pkg::SPEED_W-1:0] fan_cmd_reg,     fan_cmd_next;

    logic                        advance;
    logic                        interval_passed;
    logic [vsr_pkg::TIME_W-1:0]  elapsed;
    logic [vsr_pkg::SPEED_W:0]   spd_up;
    logic [vsr_pkg::SPEED_W-1:0] fan_now_sat;
    vsr_pkg::fan_cmd_t           law_cmd;

    // event moves into the result register when that slot is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    vsr_fan_law u_law (
        .target_pa     (target_pa_reg),
        .min_target    (min_target_reg),
        .dead_band     (dead_band_reg),
        .raw_pressure  (raw_reg),
        .fan_speed_now (fan_now_reg),
        .cmd           (law_cmd)
    );

    // wrap-safe elapsed time since the last automatic adjustment
    assign elapsed         = now_reg - last_adjust_reg;
    assign interval_passed = elapsed > adjust_interval_reg;

    assign spd_up      = {1'b0, edit_spd_reg} + 11'(vsr_pkg::SPEED_STEP);
    assign fan_now_sat = (fan_now_reg > 10'(vsr_pkg::SPEED_MAX)) ?
                         10'(vsr_pkg::SPEED_MAX) : fan_now_reg;

    // event processing
    always_comb
    begin
        auto_next        = auto_reg;
        target_pa_next   = target_pa_reg;
        target_spd_next  = target_spd_reg;
        edit_pa_next     = edit_pa_reg;
        edit_spd_next    = edit_spd_reg;
        last_adjust_next = last_adjust_reg;
        fan_write_next   = 1'b0;
        fan_cmd_next     = '0;
        unique case (cmd_reg)
            vsr_pkg::CMD_TICK:
            begin
                if (auto_reg)
                begin
                    if (interval_passed)
                    begin
                        last_adjust_next = now_reg;
                        fan_write_next   = law_cmd.write;
                        fan_cmd_next     = law_cmd.speed;
                    end
                end
                else if (target_spd_reg != fan_now_reg)
                begin
                    // manual mode applies the latched speed
                    fan_write_next = 1'b1;
                    fan_cmd_next   = target_spd_reg;
                end
            end
            vsr_pkg::CMD_UP:
            begin
                if (auto_reg)
                begin
                    if (edit_pa_reg < 7'(vsr_pkg::PRESSURE_MAX))
                        edit_pa_next = edit_pa_reg + 7'(vsr_pkg::PA_STEP);
                end
                else if (spd_up > 11'(vsr_pkg::SPEED_MAX))
                    edit_spd_next = 10'(vsr_pkg::SPEED_MAX);
                else
                    edit_spd_next = spd_up[vsr_pkg::SPEED_W-1:0];
            end
            vsr_pkg::CMD_DOWN:
            begin
                if (auto_reg)
                begin
                    if (edit_pa_reg != '0)
                        edit_pa_next = edit_pa_reg - 7'(vsr_pkg::PA_STEP);
                end
                else if (edit_spd_reg < 10'(vsr_pkg::SPEED_STEP))
                    edit_spd_next = '0;
                else
                    edit_spd_next = edit_spd_reg - 10'(vsr_pkg::SPEED_STEP);
            end
            vsr_pkg::CMD_SET:
            begin
                if (auto_reg)
                    target_pa_next = edit_pa_reg;
                else
                    target_spd_next = edit_spd_reg;
            end
            vsr_pkg::CMD_BACK:
            begin
                if (auto_reg)
                    edit_pa_next = target_pa_reg;
                else
                    edit_spd_next = target_spd_reg;
            end
            vsr_pkg::CMD_TOGGLE:
            begin
                // flip mode, reload both pending values and take the saturated current speed as fan target
                auto_next       = !auto_reg;
                edit_pa_next    = target_pa_reg;
                edit_spd_next   = fan_now_sat;
                target_spd_next = fan_now_sat;
            end
            default:
            begin
                // unused codes leave everything as is
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adjust_interval_reg <= vsr_pkg::ADJUST_INTERVAL_RST;
            min_target_reg      <= vsr_pkg::MIN_TARGET_RST;
            dead_band_reg       <= vsr_pkg::DEAD_BAND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == vsr_pkg::REG_ADJUST_INTERVAL)
                adjust_interval_reg <= cfg_data;
            else if (cfg_index == vsr_pkg::REG_MIN_TARGET)
                min_target_reg <= cfg_data[vsr_pkg::PA_W-1:0];
            else if (cfg_index == vsr_pkg::REG_DEAD_BAND)
                dead_band_reg <= cfg_data[vsr_pkg::PA_W-1:0];
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg     <= command;
            now_reg     <= now_us;
            raw_reg     <= raw_pressure;
            fan_now_reg <= fan_speed_now;
        end
    end

    // setpoint state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg        <= 1'b1;
            target_pa_reg   <= '0;
            target_spd_reg  <= '0;
            edit_pa_reg     <= '0;
            edit_spd_reg    <= '0;
            last_adjust_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                auto_reg        <= auto_next;
                target_pa_reg   <= target_pa_next;
                target_spd_reg  <= target_spd_next;
                edit_pa_reg     <= edit_pa_next;
                edit_spd_reg    <= edit_spd_next;
                last_adjust_reg <= last_adjust_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fan_write_reg <= fan_write_next;
            fan_cmd_reg   <= fan_cmd_next;
        end
    end

    // state registers hold the post-event values shown with each result beat
    assign out_valid        = out_valid_reg;
    assign fan_write        = fan_write_reg;
    assign fan_command      = fan_cmd_reg;
    assign auto_mode        = auto_reg;
    assign pressure_target  = target_pa_reg;
    assign fan_target       = target_spd_reg;
    assign pending_pressure = edit_pa_reg;
    assign pending_fan      = edit_spd_reg;

endmodule

`default_nettype wire

>>> sv/vsr_checker.sv
// port-level checks for the ventilation setpoint regulator, bound to the top level
// depends on vsr_pkg and ventilation_setpoint_regulator

`default_nettype none

module vsr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          fan_write,
    input wire logic [vsr_pkg::SPEED_W-1:0]   fan_command,
    input wire logic                          auto_mode,
    input wire logic [vsr_pkg::PA_W-1:0]      pending_pressure,
    input wire logic [vsr_pkg::SPEED_W-1:0]   fan_target,
    input wire logic [vsr_pkg::SPEED_W-1:0]   pending_fan
);

    // a stalled result beat holds its command
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fan_command) && $stable(fan_write))
        else $error("result beat changed while stalled");

    // no write means a zero command
    a_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fan_write |-> fan_command == '0)
        else $error("fan command nonzero without write");

    // manual mode only ever commands the latched speed
    a_manual: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fan_write && !auto_mode |-> fan_command == fan_target)
        else $error("manual command differs from fan target");

    // saturation of command and pending values
    a_limits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fan_command <= 10'(vsr_pkg::SPEED_MAX)
                      && pending_fan <= 10'(vsr_pkg::SPEED_MAX)
                      && pending_pressure <= 7'(vsr_pkg::PRESSURE_MAX))
        else $error("value beyond saturation limit");

endmodule

bind ventilation_setpoint_regulator vsr_checker u_vsr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .fan_write        (fan_write),
    .fan_command      (fan_command),
    .auto_mode        (auto_mode),
    .pending_pressure (pending_pressure),
    .fan_target       (fan_target),
    .pending_fan      (pending_fan)
);

`default_nettype wire
